### hw/rtl/fcm_tree_sketch_counter_core_assert.svh
// Assertion macros for the tree sketch counter core.
// Needs signals named clk and rst_n in the scope that uses the macros.
`ifndef FCM_TREE_SKETCH_COUNTER_CORE_ASSERT_SVH
`define FCM_TREE_SKETCH_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define FCMTS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define FCMTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/fcmts_pkg.sv
// Shared types and constants of the tree sketch counter core.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package fcmts_pkg;

  localparam int NUM_TREES = 2;
  localparam int THR_W     = 32;
  localparam int SUM_W     = THR_W + 1;
  localparam int AMT_W     = 16;
  localparam int ACC_W     = 34;
  localparam int EST_W     = 31;
  localparam int IDX_W     = 12;
  localparam int LVL_W     = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [ACC_W-1:0] EST_SAT_MAX = ACC_W'(32'h7FFF_FFFF);

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR0   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR1   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THR2   = 2'd3;

  localparam logic [LVL_W-1:0] LVL_LEAF   = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MIDDLE = 2'd1;
  localparam logic [LVL_W-1:0] LVL_TOP    = 2'd2;

  // Operands handed to the per-tree level update logic.
  typedef struct packed {
    logic             is_query;
    logic [AMT_W-1:0] amount;
    logic [THR_W-1:0] thr;
  } level_op_t;

  // Outcome of one level: write-back, carry and query accumulation.
  typedef struct packed {
    logic             wr_en;
    logic [THR_W-1:0] wr_data;
    logic [AMT_W-1:0] carry;
    logic             stop;
    logic [ACC_W-1:0] acc;
  } level_res_t;

  // A threshold of zero behaves as one.
  function automatic logic [THR_W-1:0] thr_eff(input logic [THR_W-1:0] v);
    thr_eff = (v == '0) ? THR_W'(1) : v;
  endfunction

endpackage

### hw/rtl/fcmts_counter_mem.sv
// Counter memory of one tree: one write port, one read port, registered read data.
// Depends on fcmts_pkg for the counter width.
`timescale 1ns / 1ps

module fcmts_counter_mem #(
  parameter  int DEPTH  = 7168,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [ADDR_W-1:0]            waddr,
  input  logic [fcmts_pkg::THR_W-1:0]  wdata,
  input  logic                         re,
  input  logic [ADDR_W-1:0]            raddr,
  output logic [fcmts_pkg::THR_W-1:0]  rdata
);

  logic [fcmts_pkg::THR_W-1:0] mem [DEPTH];
  logic [fcmts_pkg::THR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/fcmts_level_alu.sv
// Read-modify-write logic for one counter level of one tree.
// Depends on fcmts_pkg for the level operand and result structs.
`timescale 1ns / 1ps

module fcmts_level_alu (
  input  fcmts_pkg::level_op_t          op,
  input  logic [fcmts_pkg::THR_W-1:0]   old_count,
  input  logic [fcmts_pkg::ACC_W-1:0]   acc_in,
  output fcmts_pkg::level_res_t         res
);

  logic [fcmts_pkg::SUM_W-1:0] sum;
  logic [fcmts_pkg::SUM_W-1:0] thr_ext;

  always_comb begin
    sum     = {1'b0, old_count} + fcmts_pkg::SUM_W'(op.amount);
    thr_ext = {1'b0, op.thr};
    res         = '0;
    res.carry   = op.amount;
    res.acc     = acc_in;
    if (op.is_query) begin
      // A marked counter stands for threshold minus one; anything else ends the walk.
      if (old_count == op.thr) begin
        res.acc = acc_in + fcmts_pkg::ACC_W'(op.thr - fcmts_pkg::THR_W'(1));
      end else begin
        res.acc  = acc_in + fcmts_pkg::ACC_W'(old_count);
        res.stop = 1'b1;
      end
    end else if (sum < thr_ext) begin
      res.wr_en   = 1'b1;
      res.wr_data = sum[fcmts_pkg::THR_W-1:0];
      res.stop    = 1'b1;
    end else if (old_count < op.thr) begin
      // Mark the counter and carry what did not fit below the marker.
      res.wr_en   = 1'b1;
      res.wr_data = op.thr;
      res.carry   = fcmts_pkg::AMT_W'(sum - thr_ext + fcmts_pkg::SUM_W'(1));
    end
  end

endmodule

### hw/rtl/fcm_tree_sketch_counter_core.sv
// Frequency-counting tree sketch core: two counter trees held in two counter memories.
// Depends on fcmts_pkg, fcmts_counter_mem, fcmts_level_alu and the assertion macro header.
`timescale 1ns / 1ps
`include "fcm_tree_sketch_counter_core_assert.svh"

// The core keeps two trees of 32-bit counters (leaf, middle and top level), one tree
// per single-port-read, single-port-write memory, where the middle counter above a
// leaf sits at half its position and the top counter at a quarter. An insert adds the
// increment at each tree's leaf; a counter that would reach its level threshold is
// set to the threshold as an overflow marker and the rest carries one level up. A
// query walks each tree from the leaf, adds threshold minus one for each marked
// level and the value of the first unmarked counter, and returns the smaller of the
// two tree sums, saturated to 2147483647. Inserts return nothing.
// After reset the core runs a clearing pass over all 7*LEAF_COUNT/4 entries of each memory
// (7168 at the default size) with in_stall high; configuration writes are taken throughout.
// Each memory gives one read and one write per cycle, and a level's address depends
// only on the leaf position, so the next level is read while this one is written.
// An insert walks the levels it touches in ST_RUN and returns to ST_IDLE; a query then
// passes through ST_EMIT, where its result waits for a free output register. The walk
// stops early once both trees have finished.
// LEAF_COUNT must be a power of two; leaf indices are taken modulo LEAF_COUNT.
module fcm_tree_sketch_counter_core #(
  parameter int LEAF_COUNT = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic [fcmts_pkg::IDX_W-1:0]       in_leaf_index_0,
  input  logic [fcmts_pkg::IDX_W-1:0]       in_leaf_index_1,
  input  logic [fcmts_pkg::AMT_W-1:0]       in_increment,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fcmts_pkg::EST_W-1:0]       out_estimate,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fcmts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcmts_pkg::THR_W-1:0]       cfg_data
);

  localparam int NT        = fcmts_pkg::NUM_TREES;
  localparam int LEAF_BITS = $clog2(LEAF_COUNT);
  localparam int MEM_DEPTH = LEAF_COUNT + LEAF_COUNT / 2 + LEAF_COUNT / 4;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam logic [ADDR_W-1:0] BASE_MIDDLE = ADDR_W'(LEAF_COUNT);
  localparam logic [ADDR_W-1:0] BASE_TOP    = ADDR_W'(LEAF_COUNT + LEAF_COUNT / 2);
  localparam logic [ADDR_W-1:0] CLR_LAST    = ADDR_W'(MEM_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_t;

  // Memory address of a tree's counter at a given level above a leaf position.
  function automatic logic [ADDR_W-1:0] lvl_addr(input logic [LEAF_BITS-1:0] pos,
                                                 input logic [fcmts_pkg::LVL_W-1:0] lvl);
    logic [ADDR_W-1:0] a;
    case (lvl)
      fcmts_pkg::LVL_LEAF:   a = ADDR_W'(pos);
      fcmts_pkg::LVL_MIDDLE: a = BASE_MIDDLE + ADDR_W'(pos >> 1);
      default:               a = BASE_TOP + ADDR_W'(pos >> 2);
    endcase
    return a;
  endfunction

  // Configuration registers.
  logic [fcmts_pkg::LVL_W-1:0] levels_r;
  logic [fcmts_pkg::THR_W-1:0] thr0_r;
  logic [fcmts_pkg::THR_W-1:0] thr1_r;
  logic [fcmts_pkg::THR_W-1:0] thr2_r;

  // Control state.
  state_t                      state_r,     state_nxt;
  logic [ADDR_W-1:0]           clr_addr_r,  clr_addr_nxt;
  logic [fcmts_pkg::LVL_W-1:0] lvl_r,       lvl_nxt;
  logic [NT-1:0]               done_r,      done_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // Per-transaction payload.
  logic                        kind_r,      kind_nxt;
  logic [LEAF_BITS-1:0]        pos_r       [NT];
  logic [LEAF_BITS-1:0]        pos_nxt     [NT];
  logic [ADDR_W-1:0]           addr_r      [NT];
  logic [ADDR_W-1:0]           addr_nxt    [NT];
  logic [fcmts_pkg::AMT_W-1:0] amount_r    [NT];
  logic [fcmts_pkg::AMT_W-1:0] amount_nxt  [NT];
  logic [fcmts_pkg::ACC_W-1:0] acc_r       [NT];
  logic [fcmts_pkg::ACC_W-1:0] acc_nxt     [NT];
  logic [fcmts_pkg::EST_W-1:0] est_r,       est_nxt;

  // Memory ports and level logic.
  logic                        mem_we      [NT];
  logic [ADDR_W-1:0]           mem_waddr   [NT];
  logic [fcmts_pkg::THR_W-1:0] mem_wdata   [NT];
  logic                        mem_re      [NT];
  logic [ADDR_W-1:0]           mem_raddr   [NT];
  logic [fcmts_pkg::THR_W-1:0] mem_rdata   [NT];
  fcmts_pkg::level_op_t        lvl_op;
  fcmts_pkg::level_res_t       lvl_res     [NT];

  logic [LEAF_BITS-1:0]        in_pos      [NT];
  logic [fcmts_pkg::LVL_W-1:0] n_act;
  logic                        last_lvl;
  logic                        finish;
  logic                        in_accept;
  logic                        out_free;
  logic [fcmts_pkg::THR_W-1:0] thr_cur;
  logic [fcmts_pkg::ACC_W-1:0] acc_min;

  assign in_pos[0] = LEAF_BITS'(in_leaf_index_0);
  assign in_pos[1] = LEAF_BITS'(in_leaf_index_1);

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // A levels setting of zero behaves as one active level.
  assign n_act    = (levels_r == '0) ? fcmts_pkg::LVL_W'(1) : levels_r;
  assign last_lvl = (lvl_r == n_act - fcmts_pkg::LVL_W'(1));

  always_comb begin
    case (lvl_r)
      fcmts_pkg::LVL_LEAF:   thr_cur = fcmts_pkg::thr_eff(thr0_r);
      fcmts_pkg::LVL_MIDDLE: thr_cur = fcmts_pkg::thr_eff(thr1_r);
      default:               thr_cur = fcmts_pkg::thr_eff(thr2_r);
    endcase
  end

  // Both trees share the level's threshold and the operation; the amount is per tree,
  // so only the shared fields come from here.
  assign lvl_op.is_query = (kind_r == fcmts_pkg::KIND_QUERY);
  assign lvl_op.thr      = thr_cur;
  assign lvl_op.amount   = '0;

  genvar t;
  generate
    for (t = 0; t < NT; t++) begin : g_tree
      fcmts_pkg::level_op_t tree_op;

      always_comb begin
        tree_op        = lvl_op;
        tree_op.amount = amount_r[t];
      end

      fcmts_counter_mem #(
        .DEPTH (MEM_DEPTH)
      ) u_mem (
        .clk   (clk),
        .we    (mem_we[t]),
        .waddr (mem_waddr[t]),
        .wdata (mem_wdata[t]),
        .re    (mem_re[t]),
        .raddr (mem_raddr[t]),
        .rdata (mem_rdata[t])
      );

      fcmts_level_alu u_alu (
        .op        (tree_op),
        .old_count (mem_rdata[t]),
        .acc_in    (acc_r[t]),
        .res       (lvl_res[t])
      );
    end
  endgenerate

  // The walk ends at the last active level or once both trees have stopped.
  always_comb begin
    logic all_stop;
    all_stop = 1'b1;
    for (int i = 0; i < NT; i++) begin
      all_stop = all_stop & (done_r[i] | lvl_res[i].stop);
    end
    finish = last_lvl | all_stop;
  end

  assign acc_min = (acc_r[0] < acc_r[1]) ? acc_r[0] : acc_r[1];

  // Next-state logic. Each memory sees at most one read and one write per cycle, and
  // the write of a level never meets a read of the same entry: levels of one
  // transaction lie in separate regions, and the next transaction reads only after
  // the last write of the previous one has landed.
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    lvl_nxt       = lvl_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r & out_stall;
    kind_nxt      = kind_r;
    est_nxt       = est_r;
    for (int i = 0; i < NT; i++) begin
      pos_nxt[i]    = pos_r[i];
      addr_nxt[i]   = addr_r[i];
      amount_nxt[i] = amount_r[i];
      acc_nxt[i]    = acc_r[i];
      mem_we[i]     = 1'b0;
      mem_waddr[i]  = addr_r[i];
      mem_wdata[i]  = lvl_res[i].wr_data;
      mem_re[i]     = 1'b0;
      mem_raddr[i]  = lvl_addr(pos_r[i], fcmts_pkg::LVL_W'(lvl_r + fcmts_pkg::LVL_W'(1)));
    end

    case (state_r)
      ST_CLEAR: begin
        for (int i = 0; i < NT; i++) begin
          mem_we[i]    = 1'b1;
          mem_waddr[i] = clr_addr_r;
          mem_wdata[i] = '0;
        end
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          kind_nxt  = in_kind;
          lvl_nxt   = fcmts_pkg::LVL_LEAF;
          done_nxt  = '0;
          state_nxt = ST_RUN;
          for (int i = 0; i < NT; i++) begin
            mem_re[i]     = 1'b1;
            mem_raddr[i]  = lvl_addr(in_pos[i], fcmts_pkg::LVL_LEAF);
            pos_nxt[i]    = in_pos[i];
            addr_nxt[i]   = lvl_addr(in_pos[i], fcmts_pkg::LVL_LEAF);
            amount_nxt[i] = in_increment;
            acc_nxt[i]    = '0;
          end
        end
      end

      ST_RUN: begin
        for (int i = 0; i < NT; i++) begin
          mem_we[i] = !done_r[i] && lvl_res[i].wr_en;
          if (!done_r[i]) begin
            amount_nxt[i] = lvl_res[i].carry;
            acc_nxt[i]    = lvl_res[i].acc;
          end
          done_nxt[i] = done_r[i] | lvl_res[i].stop;
          addr_nxt[i] = mem_raddr[i];
          mem_re[i]   = !finish;
        end
        if (finish) begin
          state_nxt = (kind_r == fcmts_pkg::KIND_QUERY) ? ST_EMIT : ST_IDLE;
        end else begin
          lvl_nxt = fcmts_pkg::LVL_W'(lvl_r + fcmts_pkg::LVL_W'(1));
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          est_nxt       = (acc_min > fcmts_pkg::EST_SAT_MAX) ?
                          fcmts_pkg::EST_SAT_MAX[fcmts_pkg::EST_W-1:0] :
                          acc_min[fcmts_pkg::EST_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control state and registered output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      lvl_r       <= fcmts_pkg::LVL_LEAF;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      lvl_r       <= lvl_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    est_r  <= est_nxt;
    for (int i = 0; i < NT; i++) begin
      pos_r[i]    <= pos_nxt[i];
      addr_r[i]   <= addr_nxt[i];
      amount_r[i] <= amount_nxt[i];
      acc_r[i]    <= acc_nxt[i];
    end
  end

  // Configuration registers; writes must arrive only while the core is idle, which the core does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= fcmts_pkg::LVL_W'(3);
      thr0_r   <= fcmts_pkg::THR_W'(255);
      thr1_r   <= fcmts_pkg::THR_W'(65535);
      thr2_r   <= 32'hFFFF_FFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fcmts_pkg::CFG_LEVELS: levels_r <= cfg_data[fcmts_pkg::LVL_W-1:0];
        fcmts_pkg::CFG_THR0:   thr0_r   <= cfg_data;
        fcmts_pkg::CFG_THR1:   thr1_r   <= cfg_data;
        fcmts_pkg::CFG_THR2:   thr2_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_estimate = est_r;

  // The memories are never written while the core waits for a transaction.
  `FCMTS_ASSERT_IMPLY(a_no_write_idle, state_r == ST_IDLE, !mem_we[0] && !mem_we[1], "counter write while idle")
  // The level walk never goes past the last active level.
  `FCMTS_ASSERT_IMPLY(a_lvl_bound, state_r == ST_RUN, lvl_r < n_act, "level walk beyond active levels")
  // A query result that finds the output register free is presented next cycle.
  `FCMTS_ASSERT_NEXT(a_emit_out, state_r == ST_EMIT && out_free, out_valid_r && state_r == ST_IDLE, "query result not presented")
  // Transactions are taken only after the clearing pass has ended.
  `FCMTS_ASSERT_IMPLY(a_no_accept_clear, state_r == ST_CLEAR, in_stall, "transaction accepted during clearing")

endmodule
